### src/dfp_pkg.sv
// shared types and constants for the divergence-free projection pipeline
`default_nettype none
package dfp_pkg;
   localparam int LANES     = 6;
   localparam int QBITS     = 32;
   localparam int KSQ_W     = 14;
   localparam int PROD_W    = 39;
   localparam int DOT_W     = 40;
   localparam int NUM_W     = 47;
   localparam int FRONT_STG = 4;

   typedef struct packed {
      logic                            corr;
      logic                            zero;
      logic [KSQ_W-1:0]                ksq;
      logic [2:0][6:0]                 k;
      logic [LANES-1:0][31:0]          b;
      logic [LANES-1:0][PROD_W-1:0]    prod;
      logic [1:0][DOT_W-1:0]           dot;
      logic [LANES-1:0][NUM_W-1:0]     num;
      logic [LANES-1:0]                neg;
      logic [LANES-1:0]                ovf;
      logic [LANES-1:0][QBITS-1:0]     mag;
      logic [LANES-1:0][KSQ_W-1:0]     rem;
      logic [LANES-1:0][QBITS-1:0]     quo;
   } item_type;

   typedef struct packed {
      logic [LANES-1:0][31:0] p;
      logic [DOT_W-1:0]       div_re;
      logic [DOT_W-1:0]       div_im;
   } result_type;
endpackage
`default_nettype wire

### src/dfp_ifs.sv
// channel interfaces for request, response and csr write
`default_nettype none
interface dfp_req_if;
   logic              valid;
   logic              ready;
   logic signed [6:0] wave_x;
   logic signed [6:0] wave_y;
   logic [5:0]        wave_z;
   logic signed [31:0] bx_re, bx_im, by_re, by_im, bz_re, bz_im;
   modport source (output valid, wave_x, wave_y, wave_z, bx_re, bx_im, by_re, by_im,
                   bz_re, bz_im, input ready);
   modport sink (input valid, wave_x, wave_y, wave_z, bx_re, bx_im, by_re, by_im,
                 bz_re, bz_im, output ready);
endinterface

interface dfp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] px_re, px_im, py_re, py_im, pz_re, pz_im;
   logic signed [39:0] div_re, div_im;
   modport source (output valid, px_re, px_im, py_re, py_im, pz_re, pz_im, div_re, div_im,
                   input ready);
   modport sink (input valid, px_re, px_im, py_re, py_im, pz_re, pz_im, div_re, div_im,
                 output ready);
endinterface

interface dfp_csr_if;
   logic valid;
   logic ready;
   logic data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

### src/dfp_front.sv
// front stages: products, dot sums, numerators, rounding and divider setup
`default_nettype none
module dfp_front (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic              corr,
   input  wire logic [6:0]        wave_x,
   input  wire logic [6:0]        wave_y,
   input  wire logic [5:0]        wave_z,
   input  wire logic [5:0][31:0]  b_in,
   output dfp_pkg::item_type      item_out
);
   import dfp_pkg::*;

   item_type s0_in, s0_ff, s1_in, s1_ff, s2_in, s2_ff, s3_in, s3_ff;

   always_comb begin
      logic signed [6:0]        kk;
      logic [NUM_W-1:0]         absv;
      logic [NUM_W-1:0]         mag_r;
      logic signed [DOT_W+1:0]  acc_re, acc_im;
      s0_in = '0;
      s0_in.corr = corr;
      s0_in.k[0] = wave_x;
      s0_in.k[1] = wave_y;
      s0_in.k[2] = {1'b0, wave_z};
      s0_in.b = b_in;
      s0_in.ksq = KSQ_W'($signed(wave_x) * $signed(wave_x))
                + KSQ_W'($signed(wave_y) * $signed(wave_y))
                + KSQ_W'(wave_z * wave_z);
      s0_in.zero = (wave_x == '0) && (wave_y == '0) && (wave_z == '0);
      for (int l = 0; l < LANES; l++) begin
         kk = $signed(s0_in.k[l >> 1]);
         s0_in.prod[l] = PROD_W'(PROD_W'(kk) * PROD_W'($signed(b_in[l])));
      end

      // dot sums, even lanes real, odd lanes imaginary
      s1_in = s0_ff;
      acc_re = '0;
      acc_im = '0;
      for (int i = 0; i < 3; i++) begin
         acc_re = acc_re + (DOT_W+2)'($signed(s0_ff.prod[2*i]));
         acc_im = acc_im + (DOT_W+2)'($signed(s0_ff.prod[2*i+1]));
      end
      s1_in.dot[0] = acc_re[DOT_W-1:0];
      s1_in.dot[1] = acc_im[DOT_W-1:0];

      s2_in = s1_ff;
      for (int l = 0; l < LANES; l++) begin
         kk = $signed(s1_ff.k[l >> 1]);
         s2_in.num[l] = NUM_W'(NUM_W'(kk) * NUM_W'($signed(s1_ff.dot[l & 1])));
      end

      // magnitude plus half divisor for round half away from zero
      s3_in = s2_ff;
      for (int l = 0; l < LANES; l++) begin
         s3_in.neg[l] = s2_ff.num[l][NUM_W-1];
         absv = s3_in.neg[l] ? NUM_W'(-s2_ff.num[l]) : s2_ff.num[l];
         mag_r = absv + NUM_W'(s2_ff.ksq >> 1);
         s3_in.ovf[l] = mag_r[NUM_W-1:QBITS] >= {1'b0, s2_ff.ksq};
         s3_in.rem[l] = mag_r[QBITS+KSQ_W-1:QBITS];
         s3_in.mag[l] = mag_r[QBITS-1:0];
         s3_in.quo[l] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_ff <= s0_in;
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
      end
   end

   assign item_out = s3_ff;
endmodule
`default_nettype wire

### src/dfp_div_stage.sv
// one restoring-division step for all six lanes
`default_nettype none
module dfp_div_stage #(
   parameter int BIT = 0
) (
   input  wire logic          clock,
   input  wire logic          en,
   input  wire dfp_pkg::item_type item_in,
   output dfp_pkg::item_type  item_out
);
   import dfp_pkg::*;

   item_type st_in, st_ff;

   always_comb begin
      logic [KSQ_W:0] rem_sh;
      st_in = item_in;
      for (int l = 0; l < LANES; l++) begin
         rem_sh = {item_in.rem[l], item_in.mag[l][BIT]};
         if (rem_sh >= {1'b0, item_in.ksq}) begin
            st_in.rem[l] = KSQ_W'(rem_sh - {1'b0, item_in.ksq});
            st_in.quo[l][BIT] = 1'b1;
         end else begin
            st_in.rem[l] = rem_sh[KSQ_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff <= st_in;
      end
   end

   assign item_out = st_ff;
endmodule
`default_nettype wire

### src/dfp_back.sv
// signed quotient saturation, subtraction and output select
`default_nettype none
module dfp_back (
   input  wire logic          clock,
   input  wire logic          en,
   input  wire dfp_pkg::item_type item_in,
   output dfp_pkg::result_type res_out
);
   import dfp_pkg::*;

   localparam logic signed [32:0] Q_MAX = 33'sd2147483647;
   localparam logic signed [32:0] Q_MIN = -33'sd2147483648;
   localparam logic signed [33:0] S_MAX = 34'sd2147483647;
   localparam logic signed [33:0] S_MIN = -34'sd2147483648;

   result_type res_in, res_ff;

   always_comb begin
      logic signed [32:0] q;
      logic signed [33:0] diff;
      logic [31:0]        sat;
      for (int l = 0; l < LANES; l++) begin
         if (item_in.ovf[l]) begin
            q = item_in.neg[l] ? Q_MIN : Q_MAX;
         end else if (!item_in.neg[l]) begin
            q = item_in.quo[l][QBITS-1] ? Q_MAX : $signed({1'b0, item_in.quo[l]});
         end else if (item_in.quo[l] > 32'h8000_0000) begin
            q = Q_MIN;
         end else begin
            q = -$signed({1'b0, item_in.quo[l]});
         end
         diff = 34'($signed(item_in.b[l])) - 34'(q);
         if (diff > S_MAX) sat = 32'h7FFF_FFFF;
         else if (diff < S_MIN) sat = 32'h8000_0000;
         else sat = diff[31:0];
         if (!item_in.corr) res_in.p[l] = item_in.b[l];
         else if (item_in.zero) res_in.p[l] = '0;
         else res_in.p[l] = sat;
      end
      res_in.div_re = DOT_W'(-item_in.dot[1]);
      res_in.div_im = item_in.dot[0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign res_out = res_ff;
endmodule
`default_nettype wire

### src/divergence_free_projection_unit.sv
// top level: projection pipeline with output register and skid word
// Streams Fourier-space points. req_ch carries wavenumbers and a complex field
// vector; rsp_ch returns the projected vector and the spectral divergence.
// csr_ch writes correction_enable (always ready, reset value 1); write it only
// while no word is in flight.
// From request accept to response valid, a word passes the 4 front stages
// (products, dot sums, numerators, rounding setup), 32 one-bit restoring
// division stages, one saturation stage and the output register.
// Throughput is one word per cycle while req_ch.ready is high; the 32-step
// divider is fully pipelined.
// When the receiver stalls, the pipeline keeps moving until one extra word
// sits in a skid register, then req_ch.ready drops until the output drains.
// Nothing is lost or repeated under stalls.
// Reset (synchronous) clears all valid bits and sets correction_enable.
`default_nettype none
module divergence_free_projection_unit (
   input wire logic clock,
   input wire logic reset,
   dfp_req_if.sink  req_ch,
   dfp_rsp_if.source rsp_ch,
   dfp_csr_if.sink  csr_ch
);
   import dfp_pkg::*;

   localparam int DIV_STG = QBITS;
   localparam int N_STG   = FRONT_STG + DIV_STG + 1;

   logic             corr_ff;
   logic [N_STG-1:0] v_ff;
   logic             adv;
   logic             out_v_ff, skid_v_ff;
   result_type       out_ff, skid_ff, pipe_res;
   item_type         chain [DIV_STG+1];

   assign adv = !skid_v_ff;
   assign req_ch.ready = adv;
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         corr_ff <= 1'b1;
      end else if (csr_ch.valid) begin
         corr_ff <= csr_ch.data;
      end
   end

   dfp_front u_front (
      .clock   (clock),
      .en      (adv),
      .corr    (corr_ff),
      .wave_x  (req_ch.wave_x),
      .wave_y  (req_ch.wave_y),
      .wave_z  (req_ch.wave_z),
      .b_in    ({req_ch.bz_im, req_ch.bz_re, req_ch.by_im, req_ch.by_re,
                 req_ch.bx_im, req_ch.bx_re}),
      .item_out(chain[0])
   );

   // quotient bits from msb down
   for (genvar j = 0; j < DIV_STG; j++) begin : g_div
      dfp_div_stage #(.BIT(DIV_STG - 1 - j)) u_stage (
         .clock   (clock),
         .en      (adv),
         .item_in (chain[j]),
         .item_out(chain[j+1])
      );
   end

   dfp_back u_back (
      .clock  (clock),
      .en     (adv),
      .item_in(chain[DIV_STG]),
      .res_out(pipe_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[N_STG-2:0], req_ch.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || rsp_ch.ready) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff <= v_ff[N_STG-1];
         end
      end else if (adv && v_ff[N_STG-1]) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || rsp_ch.ready) begin
         out_ff <= skid_v_ff ? skid_ff : pipe_res;
      end else if (adv && v_ff[N_STG-1]) begin
         skid_ff <= pipe_res;
      end
   end

   assign rsp_ch.valid  = out_v_ff;
   assign rsp_ch.px_re  = out_ff.p[0];
   assign rsp_ch.px_im  = out_ff.p[1];
   assign rsp_ch.py_re  = out_ff.p[2];
   assign rsp_ch.py_im  = out_ff.p[3];
   assign rsp_ch.pz_re  = out_ff.p[4];
   assign rsp_ch.pz_im  = out_ff.p[5];
   assign rsp_ch.div_re = out_ff.div_re;
   assign rsp_ch.div_im = out_ff.div_im;
endmodule
`default_nettype wire

### src/dfp_checker.sv
// port-level checks for the projection unit, bound to the top level
`default_nettype none
module dfp_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready
);
   // input back-pressure only while a word is waiting at the output
   a_stall_src: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled with no response pending");

   a_reset_clr: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("state not cleared by reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");
endmodule

bind divergence_free_projection_unit dfp_checker u_dfp_checker (
   .clock    (clock),
   .reset    (reset),
   .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready)
);
`default_nettype wire

### dv/dfp_tb_ifs.sv
// testbench types: expected response word
`timescale 1ns / 1ps
package dfp_tb_types;
   typedef struct {
      logic signed [31:0] p [6];
      logic signed [39:0] div_re;
      logic signed [39:0] div_im;
   } proj_word_type;
endpackage

### dv/divergence_free_projection_unit_tb.sv
// self-checking testbench for the divergence-free projection unit
`timescale 1ns / 1ps
module divergence_free_projection_unit_tb;
   import dfp_tb_types::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   errors = 0;
   logic enable_shadow = 1'b1;
   proj_word_type expected_words[$];

   dfp_req_if req_ch();
   dfp_rsp_if rsp_ch();
   dfp_csr_if csr_ch();

   divergence_free_projection_unit u_top (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.wave_x = '0; req_ch.wave_y = '0; req_ch.wave_z = '0;
      req_ch.bx_re = '0; req_ch.bx_im = '0; req_ch.by_re = '0;
      req_ch.by_im = '0; req_ch.bz_re = '0; req_ch.bz_im = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.data = 1'b0;
   end

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint round_div(longint n, longint d);
      longint mag;
      mag = (n < 0) ? -n : n;
      mag = (mag + d / 2) / d;
      return (n < 0) ? -mag : mag;
   endfunction

   function automatic proj_word_type project(logic signed [6:0] kx, logic signed [6:0] ky,
                                             logic [5:0] kz, logic signed [31:0] b [6]);
      proj_word_type w;
      longint k [3];
      longint dot_re, dot_im, ksq, q;
      k[0] = longint'(kx); k[1] = longint'(ky); k[2] = longint'({1'b0, kz});
      dot_re = 0; dot_im = 0;
      for (int i = 0; i < 3; i++) begin
         dot_re += k[i] * longint'(b[2*i]);
         dot_im += k[i] * longint'(b[2*i+1]);
      end
      ksq = k[0]*k[0] + k[1]*k[1] + k[2]*k[2];
      w.div_re = 40'(-dot_im);
      w.div_im = 40'(dot_re);
      for (int i = 0; i < 3; i++) begin
         if (!enable_shadow) begin
            w.p[2*i] = b[2*i]; w.p[2*i+1] = b[2*i+1];
         end else if (ksq == 0) begin
            w.p[2*i] = '0; w.p[2*i+1] = '0;
         end else begin
            q = sat32(round_div(k[i] * dot_re, ksq));
            w.p[2*i] = 32'(sat32(longint'(b[2*i]) - q));
            q = sat32(round_div(k[i] * dot_im, ksq));
            w.p[2*i+1] = 32'(sat32(longint'(b[2*i+1]) - q));
         end
      end
      return w;
   endfunction

   function automatic int gap_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   // 0 always ready, 1 random stalls
   int stall_mode = 1;
   initial begin
      forever begin
         @(negedge clock);
         if (stall_mode == 0) rsp_ch.ready = 1'b1;
         else if ($urandom_range(0, 49) == 0) rsp_ch.ready = 1'b0;
         else if (!rsp_ch.ready) rsp_ch.ready = ($urandom_range(0, 5) == 0);
         else rsp_ch.ready = ($urandom_range(0, 7) != 0);
      end
   end

   initial begin
      proj_word_type e;
      logic signed [31:0] got [6];
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.px_re, rsp_ch.px_im, rsp_ch.py_re, rsp_ch.py_im,
                    rsp_ch.pz_re, rsp_ch.pz_im};
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word", $time);
               errors++;
            end else begin
               e = expected_words.pop_front();
               for (int i = 0; i < 6; i++)
                  if (got[i] !== e.p[i]) begin
                     $display("%0t: p[%0d] expected %h actual %h", $time, i, e.p[i], got[i]);
                     errors++;
                  end
               if (rsp_ch.div_re !== e.div_re) begin
                  $display("%0t: div_re expected %h actual %h", $time, e.div_re,
                           rsp_ch.div_re);
                  errors++;
               end
               if (rsp_ch.div_im !== e.div_im) begin
                  $display("%0t: div_im expected %h actual %h", $time, e.div_im,
                           rsp_ch.div_im);
                  errors++;
               end
            end
         end
      end
   end

   task automatic send_point(logic signed [6:0] kx, logic signed [6:0] ky, logic [5:0] kz,
                             logic signed [31:0] b [6], bit allow_gap = 1);
      int g;
      g = allow_gap ? gap_len() : 0;
      if (g > 0) begin
         req_ch.valid = 1'b0;
         repeat (g) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.wave_x = kx; req_ch.wave_y = ky; req_ch.wave_z = kz;
      req_ch.bx_re = b[0]; req_ch.bx_im = b[1]; req_ch.by_re = b[2];
      req_ch.by_im = b[3]; req_ch.bz_re = b[4]; req_ch.bz_im = b[5];
      do @(posedge clock); while (!req_ch.ready);
      expected_words.insert(expected_words.size(), project(kx, ky, kz, b));
      @(negedge clock);
   endtask

   task automatic drain();
      req_ch.valid = 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
      repeat (45) @(negedge clock);
   endtask

   task automatic write_enable(logic v);
      csr_ch.valid = 1'b1;
      csr_ch.data = v;
      do @(posedge clock); while (!csr_ch.ready);
      enable_shadow = v;
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   function automatic logic [31:0] rand_field();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(0, 255) - 128;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [6:0] rand_wave_xy();
      if ($urandom_range(0, 9) == 0) return 7'($urandom());
      return 7'($urandom_range(0, 63) - 31);
   endfunction

   task automatic test_directed();
      logic signed [31:0] b [6];
      logic signed [31:0] mx [6] = '{32'h7fffffff, 32'h80000000, 32'h7fffffff,
                                     32'h80000000, 32'h7fffffff, 32'h80000000};
      logic signed [31:0] mn [6] = '{32'h80000000, 32'h7fffffff, 32'h80000000,
                                     32'h7fffffff, 32'h80000000, 32'h7fffffff};
      b = '{32'h01000000, -32'sh01000000, 32'h00800000, 32'h12345678, -32'sd5, 32'sd7};
      send_point(0, 0, 0, b);
      send_point(0, 0, 0, mx);
      send_point(7'sd32, 7'sd32, 6'd32, mx);
      send_point(-7'sd31, -7'sd31, 6'd0, mn);
      send_point(-7'sd64, -7'sd64, 6'd63, mx);
      send_point(7'sd63, -7'sd64, 6'd63, mn);
      send_point(7'sd1, 0, 0, b);
      send_point(0, 7'sd1, 0, b);
      send_point(0, 0, 6'd1, b);
      send_point(7'sd3, -7'sd4, 6'd5, b);
      send_point(-7'sd1, 7'sd1, 6'd1, mx);
      send_point(7'sd32, -7'sd31, 6'd1, mn);
   endtask

   task automatic test_random(int n);
      logic signed [31:0] b [6];
      for (int i = 0; i < n; i++) begin
         foreach (b[j]) b[j] = rand_field();
         send_point(rand_wave_xy(), rand_wave_xy(),
                    ($urandom_range(0, 9) == 0) ? 6'($urandom()) : 6'($urandom_range(0, 32)),
                    b, i % 200 > 30);
      end
   endtask

   task automatic test_enable_toggle();
      drain();
      write_enable(1'b0);
      test_directed();
      test_random(300);
      drain();
      write_enable(1'b1);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(400);
      drain();
      stall_mode = 0;
      test_random(200);
      stall_mode = 1;
      test_enable_toggle();
      test_random(400);
      drain();
      write_enable(1'b1);
      test_random(300);
      drain();
      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   initial begin
      #4000000;
      $display("TB_ERROR");
      $finish;
   end
endmodule
